### hdl/qfd_pkg.sv
// ----------------------------------------------------------------------------
// qfd_pkg: shared types and constants of the quadrature fm discriminator
// sample and angle formats, cordic arctangent table, gain reset value
// ----------------------------------------------------------------------------
package qfd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NUM_STAGES    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    localparam int GAIN_BITS  = 16;
    localparam int OUT_BITS   = 16;
    localparam int ANGLE_BITS = 16;

    // complex product and cordic datapath widths
    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int XY_BITS   = SUM_BITS + 2;
    localparam int Z_BITS    = 34;

    // angle accumulator: 2^31 is pi, output angle takes bits [31:16]
    localparam int ANG_LSB   = 16;
    localparam int SCALE_SHIFT = 15;
    localparam int MUL_BITS  = ANGLE_BITS + GAIN_BITS + 1;
    localparam int SHR_BITS  = MUL_BITS - SCALE_SHIFT;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(32768);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [PROD_BITS-1:0]   t_prod;
    typedef logic signed [SUM_BITS-1:0]    t_sum;
    typedef logic signed [XY_BITS-1:0]     t_xy;
    typedef logic signed [Z_BITS-1:0]      t_z;
    typedef logic signed [ANGLE_BITS-1:0]  t_angle;
    typedef logic [GAIN_BITS-1:0]          t_gain;
    typedef logic signed [OUT_BITS-1:0]    t_freq;

    typedef struct packed {
        t_sum re;
        t_sum im;
    } t_cplx;

    typedef struct packed {
        t_xy  x;
        t_xy  y;
        t_z   z;
        logic zero;
    } t_vec;

    localparam t_z QUARTER_TURN = t_z'(32'h4000_0000);
    localparam t_z ROUND_HALF   = t_z'(32'h0000_8000);

    // atan(2^-k), 2^31 = pi, rounded to nearest
    localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

### hdl/qfd_in_if.sv
// ----------------------------------------------------------------------------
// qfd_in_if: complex sample channel
// valid/ready handshake carrying one i/q sample per transfer
// ----------------------------------------------------------------------------
interface qfd_in_if;
    import qfd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_i;
    t_sample sample_q;

    modport source (output valid, output sample_i, output sample_q, input ready);
    modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

### hdl/qfd_out_if.sv
// ----------------------------------------------------------------------------
// qfd_out_if: discriminator result channel
// valid/ready handshake carrying one frequency word per transfer
// ----------------------------------------------------------------------------
interface qfd_out_if;
    import qfd_pkg::*;

    logic  valid;
    logic  ready;
    t_freq freq_out;

    modport source (output valid, output freq_out, input ready);
    modport sink   (input valid, input freq_out, output ready);
endinterface

### hdl/qfd_cfg_if.sv
// ----------------------------------------------------------------------------
// qfd_cfg_if: gain register write channel
// valid/ready handshake carrying the phase gain write data
// ----------------------------------------------------------------------------
interface qfd_cfg_if;
    import qfd_pkg::*;

    logic  valid;
    logic  ready;
    t_gain phase_gain;

    modport source (output valid, output phase_gain, input ready);
    modport sink   (input valid, input phase_gain, output ready);
endinterface

### hdl/quadrature_fm_discriminator_core.sv
// a sample transfer passes the product, sum, cordic and scale registers into the output register
// throughput: one sample per clock; the whole pipeline advances as one, gated by output ready
// the stall point is the output register: a stage moves whenever the output is empty or taken
// reset (synchronous, active low) empties the pipeline, zeroes the previous sample and
// loads the phase gain with 32768; the first result after reset is always zero
// ----------------------------------------------------------------------------
// quadrature_fm_discriminator_core: pipelined quadrature fm discriminator
// conjugate product, 16-stage cordic atan2 and gain scaling on one i/q stream
// ----------------------------------------------------------------------------
module quadrature_fm_discriminator_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qfd_in_if.sink    i_sample,
    qfd_cfg_if.sink   i_cfg,
    qfd_out_if.source o_freq
);
    import qfd_pkg::*;

    // gain register, written through its own channel which never stalls
    t_gain r_phase_gain;

    // pipeline advance: the output register is free or being drained this cycle
    logic  pipe_en;

    logic  prod_valid;
    t_cplx prod;
    logic  vec_valid;
    t_vec  vec;
    logic  out_valid;
    t_freq out_freq;

    assign pipe_en        = !out_valid || o_freq.ready;
    assign i_sample.ready = pipe_en;
    assign i_cfg.ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_gain <= GAIN_RESET;
        end else if (i_cfg.valid) begin
            r_phase_gain <= i_cfg.phase_gain;
        end
    end

    // stage 1-2: products against the stored sample, then real and imaginary sums
    qfd_cmult u_cmult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_sample.valid),
        .i_i     (i_sample.sample_i),
        .i_q     (i_sample.sample_q),
        .o_valid (prod_valid),
        .o_prod  (prod)
    );

    // stage 3: half plane pre-rotation; stages 4-19: cordic micro-rotations
    qfd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (prod_valid),
        .i_prod  (prod),
        .o_valid (vec_valid),
        .o_vec   (vec)
    );

    // stage 20: round to 16-bit angle; 21: gain multiply; 22: saturate into output
    qfd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (vec_valid),
        .i_vec   (vec),
        .i_gain  (r_phase_gain),
        .o_valid (out_valid),
        .o_freq  (out_freq)
    );

    assign o_freq.valid    = out_valid;
    assign o_freq.freq_out = out_freq;
endmodule

### hdl/qfd_cmult.sv
// ----------------------------------------------------------------------------
// qfd_cmult: conjugate product front end
// multiplies the new sample by the conjugate of the previous one, two stages
// ----------------------------------------------------------------------------
module qfd_cmult (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  qfd_pkg::t_sample i_i,
    input  qfd_pkg::t_sample i_q,
    output logic            o_valid,
    output qfd_pkg::t_cplx  o_prod
);
    import qfd_pkg::*;

    t_sample r_prev_i;
    t_sample r_prev_q;
    t_prod   r_ii, r_qq, r_qi, r_iq;
    logic    r_valid_mul;
    t_cplx   r_sum;
    logic    r_valid_sum;
    t_cplx   n_sum;

    // control and sample history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_i    <= '0;
            r_prev_q    <= '0;
            r_valid_mul <= 1'b0;
            r_valid_sum <= 1'b0;
        end else if (i_en) begin
            r_valid_mul <= i_valid;
            r_valid_sum <= r_valid_mul;
            if (i_valid) begin
                r_prev_i <= i_i;
                r_prev_q <= i_q;
            end
        end
    end

    // products against previous sample
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ii  <= t_prod'(i_i) * t_prod'(r_prev_i);
            r_qq  <= t_prod'(i_q) * t_prod'(r_prev_q);
            r_qi  <= t_prod'(i_q) * t_prod'(r_prev_i);
            r_iq  <= t_prod'(i_i) * t_prod'(r_prev_q);
            r_sum <= n_sum;
        end
    end

    always_comb begin
        n_sum.re = t_sum'(r_ii) + t_sum'(r_qq);
        n_sum.im = t_sum'(r_qi) - t_sum'(r_iq);
    end

    assign o_valid = r_valid_sum;
    assign o_prod  = r_sum;

`ifndef SYNTHESIS
    a_prev_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_en && i_valid |=> (r_prev_i == $past(i_i)) && (r_prev_q == $past(i_q)))
        else $error("previous sample not captured on transfer");
`endif
endmodule

### hdl/qfd_cordic.sv
// ----------------------------------------------------------------------------
// qfd_cordic: pipelined vectoring cordic
// half plane pre-rotation, then one registered micro-rotation per stage
// ----------------------------------------------------------------------------
module qfd_cordic (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  qfd_pkg::t_cplx i_prod,
    output logic           o_valid,
    output qfd_pkg::t_vec  o_vec
);
    import qfd_pkg::*;

    t_vec r_v     [NUM_STAGES+1];
    logic r_valid [NUM_STAGES+1];
    t_vec n_pre;
    t_xy  re_x, im_y;

    // pre-rotation out of the left half plane
    always_comb begin
        re_x       = t_xy'(i_prod.re);
        im_y       = t_xy'(i_prod.im);
        n_pre.zero = (i_prod.re == '0) && (i_prod.im == '0);
        if (re_x[XY_BITS-1]) begin
            if (!im_y[XY_BITS-1]) begin
                n_pre.x = im_y;
                n_pre.y = -re_x;
                n_pre.z = QUARTER_TURN;
            end else begin
                n_pre.x = -im_y;
                n_pre.y = re_x;
                n_pre.z = -QUARTER_TURN;
            end
        end else begin
            n_pre.x = re_x;
            n_pre.y = im_y;
            n_pre.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0] <= n_pre;
        end
    end

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        t_vec n_v;
        t_xy  dx, dy;
        t_z   step;

        always_comb begin
            dx       = r_v[k].y >>> k;
            dy       = r_v[k].x >>> k;
            step     = t_z'(ATAN_TAB[k]);
            n_v.zero = r_v[k].zero;
            if (!r_v[k].y[XY_BITS-1]) begin
                n_v.x = r_v[k].x + dx;
                n_v.y = r_v[k].y - dy;
                n_v.z = r_v[k].z + step;
            end else begin
                n_v.x = r_v[k].x - dx;
                n_v.y = r_v[k].y + dy;
                n_v.z = r_v[k].z - step;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k+1] <= n_v;
            end
        end
    end

    assign o_valid = r_valid[NUM_STAGES];
    assign o_vec   = r_v[NUM_STAGES];

`ifndef SYNTHESIS
    a_pre_right_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[0] |-> !r_v[0].x[XY_BITS-1])
        else $error("pre-rotated vector left of the imaginary axis");
`endif
endmodule

### hdl/qfd_scale.sv
// ----------------------------------------------------------------------------
// qfd_scale: angle rounding and gain scaling
// rounds the cordic angle to 16 bits, multiplies by the gain, saturates
// ----------------------------------------------------------------------------
module qfd_scale (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  qfd_pkg::t_vec  i_vec,
    input  qfd_pkg::t_gain i_gain,
    output logic           o_valid,
    output qfd_pkg::t_freq o_freq
);
    import qfd_pkg::*;

    localparam logic signed [SHR_BITS-1:0] SAT_HI = SHR_BITS'(32767);
    localparam logic signed [SHR_BITS-1:0] SAT_LO = -SHR_BITS'(32768);

    t_angle r_ang;
    logic   r_valid_ang;
    logic signed [MUL_BITS-1:0] r_mul;
    logic   r_valid_mul;
    t_freq  r_out;
    logic   r_valid_out;

    t_z     z_rnd;
    t_angle n_ang;
    logic signed [SHR_BITS-1:0] shr;
    t_freq  n_out;

    always_comb begin
        z_rnd = i_vec.z + ROUND_HALF;
        n_ang = i_vec.zero ? '0 : t_angle'(z_rnd[ANG_LSB +: ANGLE_BITS]);
    end

    // floor shift and clamp to the output range
    always_comb begin
        shr = SHR_BITS'(r_mul >>> SCALE_SHIFT);
        priority if (shr > SAT_HI) begin
            n_out = t_freq'(SAT_HI);
        end else if (shr < SAT_LO) begin
            n_out = t_freq'(SAT_LO);
        end else begin
            n_out = t_freq'(shr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_ang <= 1'b0;
            r_valid_mul <= 1'b0;
            r_valid_out <= 1'b0;
        end else if (i_en) begin
            r_valid_ang <= i_valid;
            r_valid_mul <= r_valid_ang;
            r_valid_out <= r_valid_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_ang;
            r_mul <= MUL_BITS'(r_ang) * $signed({1'b0, i_gain});
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid_out;
    assign o_freq  = r_out;

`ifndef SYNTHESIS
    a_zero_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_en && r_valid_mul && (r_mul == '0) |=> (r_out == '0))
        else $error("zero scaled angle gives nonzero output");
`endif
endmodule

### tb/qfd_freq_checker.sv
// ----------------------------------------------------------------------------
// qfd_freq_checker: result checker for the quadrature fm discriminator
// watches the sample, gain and result channels, predicts each frequency word
// from its own copy of the previous sample and gain, and compares in order
// ----------------------------------------------------------------------------
module qfd_freq_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    qfd_in_if    i_sample_mon,
    qfd_cfg_if   i_cfg_mon,
    qfd_out_if   i_freq_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import qfd_pkg::*;

    localparam t_gain GAIN_AT_RESET = 16'd32768;
    localparam int    ROTATIONS     = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int    REPORT_LIMIT  = 10;

    // atan(2^-k) with 2^31 as pi
    localparam longint ARCTAN_LUT [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };
    localparam longint QUARTER = 64'h40000000;

    t_sample last_i;
    t_sample last_q;
    t_gain   gain;
    t_freq   freq_expected [$];
    int      mismatches;
    int      results_seen;

    // vectoring cordic, angle of (x, y) in 16-bit binary angle units
    function automatic t_angle angle_of(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        longint t;
        if (x == 0 && y == 0) begin
            return '0;
        end
        z = 0;
        // fold the left half plane onto the right one
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = QUARTER;
            end else begin
                x = -y;
                y = t;
                z = -QUARTER;
            end
        end
        for (int k = 0; k < ROTATIONS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_LUT[k];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_LUT[k];
            end
        end
        z = (z + 64'sd32768) >>> 16;
        return t_angle'(z);
    endfunction

    function automatic t_freq discriminate(t_sample ci, t_sample cq, t_sample old_i,
                                           t_sample old_q, t_gain g);
        longint re;
        longint im;
        longint scaled;
        t_angle ang;
        re     = longint'(ci) * longint'(old_i) + longint'(cq) * longint'(old_q);
        im     = longint'(cq) * longint'(old_i) - longint'(ci) * longint'(old_q);
        ang    = angle_of(re, im);
        scaled = (longint'(ang) * longint'(g)) >>> 15;
        if (scaled > 32767) begin
            scaled = 32767;
        end else if (scaled < -32768) begin
            scaled = -32768;
        end
        return t_freq'(scaled);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_freq got;
        t_freq want;
        if (!i_rst_n) begin
            last_i = '0;
            last_q = '0;
            gain   = GAIN_AT_RESET;
            freq_expected.delete();
            mismatches   = 0;
            results_seen = 0;
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                gain = i_cfg_mon.phase_gain;
            end
            if (i_sample_mon.valid && i_sample_mon.ready) begin
                freq_expected.push_back(discriminate(i_sample_mon.sample_i,
                    i_sample_mon.sample_q, last_i, last_q, gain));
                last_i = i_sample_mon.sample_i;
                last_q = i_sample_mon.sample_q;
            end
            if (i_freq_mon.valid && i_freq_mon.ready) begin
                got = i_freq_mon.freq_out;
                if (freq_expected.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("freq result %0d: nothing expected, got %0d",
                                 results_seen, got);
                    end
                    mismatches++;
                end else begin
                    want = freq_expected.pop_front();
                    if (got !== want) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("freq result %0d: expected %0d, got %0d",
                                     results_seen, want, got);
                        end
                        mismatches++;
                    end
                end
                results_seen++;
            end
        end
        o_pending    <= freq_expected.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/quadrature_fm_discriminator_core_tb.sv
// ----------------------------------------------------------------------------
// quadrature_fm_discriminator_core_tb: testbench of the fm discriminator core
// directed corner samples, then tone runs, noise and corner values over a
// series of gain settings; random gaps and stalls on both channels, with
// long result hold-offs that back the pipeline up into the sample input
// ----------------------------------------------------------------------------
module quadrature_fm_discriminator_core_tb;
    import qfd_pkg::*;

    localparam int  CLK_HALF         = 4;
    localparam int  RESET_CYCLES     = 10;
    localparam int  PIPE_LATENCY     = 22;
    localparam int  CYCLE_LIMIT      = 1_000_000;
    localparam int  RANDOM_PER_PHASE = 125;
    localparam int  GAIN_PHASES      = 9;
    localparam int  BACKUP_CYCLES    = 400;
    localparam real PI               = 3.14159265358979;

    // gain settings walked after the reset value, the rest are random
    localparam t_gain GAIN_STEPS [6] = '{
        16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h2000
    };

    typedef enum {RUN_TONE, RUN_NOISE, RUN_CORNER} t_run_kind;
    typedef enum {READY_ALWAYS, READY_MOSTLY, READY_COIN, READY_BURSTY} t_ready_mode;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles;

    qfd_in_if  sample_if ();
    qfd_cfg_if gain_if ();
    qfd_out_if freq_if ();

    quadrature_fm_discriminator_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_sample(sample_if),
        .i_cfg   (gain_if),
        .o_freq  (freq_if)
    );

    qfd_freq_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_sample_mon(sample_if),
        .i_cfg_mon   (gain_if),
        .i_freq_mon  (freq_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #(CLK_HALF) clk = ~clk;

    // watchdog, well above the slowest legal run
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("quadrature_fm_discriminator_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: ready in random modes, each held for a random stretch, plus
    // two long hold-offs in the middle of a sample stream so the pipeline
    // fills and the sample channel stalls
    // ------------------------------------------------------------------------
    int          samples_taken;
    int          hold_left;
    int          mode_left;
    bit [1:0]    backup_done;
    t_ready_mode ready_mode;

    always @(posedge clk) begin
        if (sample_if.valid && sample_if.ready) begin
            samples_taken++;
        end
        if (!backup_done[0] && samples_taken >= 200) begin
            backup_done[0] = 1'b1;
            hold_left      = BACKUP_CYCLES;
        end
        if (!backup_done[1] && samples_taken >= 700) begin
            backup_done[1] = 1'b1;
            hold_left      = BACKUP_CYCLES;
        end
        if (!rst_n) begin
            freq_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            freq_if.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = t_ready_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 300);
            end
            mode_left--;
            case (ready_mode)
                READY_ALWAYS: begin
                    freq_if.ready <= 1'b1;
                end
                READY_MOSTLY: begin
                    freq_if.ready <= ($urandom_range(0, 3) != 0);
                end
                READY_COIN: begin
                    freq_if.ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    // mostly ready, now and then a longer stall
                    if ($urandom_range(0, 31) == 0) begin
                        hold_left = $urandom_range(10, 60);
                        freq_if.ready <= 1'b0;
                    end else begin
                        freq_if.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------------
    bit        gapless;
    t_run_kind run_kind;
    int        run_left;
    real       tone_amp;
    real       tone_phase;
    real       tone_step;
    t_sample   last_i;
    t_sample   last_q;

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // one sample transfer; valid stays high when no gap follows
    task automatic offer(input t_sample si, input t_sample sq);
        int gap;
        sample_if.valid    <= 1'b1;
        sample_if.sample_i <= si;
        sample_if.sample_q <= sq;
        do @(posedge clk); while (!sample_if.ready);
        last_i = si;
        last_q = sq;
        gap    = gapless ? 0 : pick_gap();
        if (gap > 0) begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every expected result has been taken
    task automatic drain();
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // gain write, only with the pipeline empty
    task automatic write_gain(input t_gain g);
        drain();
        gain_if.valid      <= 1'b1;
        gain_if.phase_gain <= g;
        do @(posedge clk); while (!gain_if.ready);
        gain_if.valid <= 1'b0;
    endtask

    // runs of a rotating phasor with random amplitude and rate, broken up
    // by raw noise and corner values
    task automatic random_sample(output t_sample si, output t_sample sq);
        int r;
        if (run_left == 0) begin
            run_left = $urandom_range(4, 40);
            r        = $urandom_range(0, 99);
            run_kind = (r < 65) ? RUN_TONE : ((r < 85) ? RUN_NOISE : RUN_CORNER);
            r        = $urandom_range(0, 9);
            if (r == 0) begin
                tone_amp = $urandom_range(1, 16);
            end else if (r < 3) begin
                tone_amp = 32767.0;
            end else begin
                tone_amp = $urandom_range(100, 32767);
            end
            tone_step  = ($urandom_range(0, 65535) / 32768.0 - 1.0) * PI;
            tone_phase = ($urandom_range(0, 65535) / 32768.0 - 1.0) * PI;
        end
        run_left--;
        case (run_kind)
            RUN_TONE: begin
                tone_phase = tone_phase + tone_step;
                si = t_sample'($rtoi(tone_amp * $cos(tone_phase)));
                sq = t_sample'($rtoi(tone_amp * $sin(tone_phase)));
            end
            RUN_NOISE: begin
                si = t_sample'($urandom);
                sq = t_sample'($urandom);
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: begin si = '0; sq = '0; end
                    1: begin si = -16'sd32768; sq = -16'sd32768; end
                    2: begin si = 16'sd32767; sq = 16'sd32767; end
                    3: begin si = last_i; sq = last_q; end
                    // negated sample, a step of pi
                    4: begin si = -last_i; sq = -last_q; end
                    default: begin si = -16'sd32768; sq = 16'sd32767; end
                endcase
            end
        endcase
    endtask

    task automatic random_burst(input int n);
        t_sample si;
        t_sample sq;
        gapless = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++) begin
            random_sample(si, sq);
            offer(si, sq);
        end
    endtask

    initial begin
        t_gain g;
        rst_n              = 1'b0;
        sample_if.valid    = 1'b0;
        sample_if.sample_i = '0;
        sample_if.sample_q = '0;
        gain_if.valid      = 1'b0;
        gain_if.phase_gain = '0;
        freq_if.ready      = 1'b0;
        gapless            = 1'b0;
        run_left           = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners at the reset gain: zero product first, then quarter turns,
        // half turns that wrap to -pi, both left half plane folds
        offer(16'sd0, 16'sd0);
        offer(16'sd32767, 16'sd0);
        offer(16'sd32767, 16'sd0);
        offer(16'sd0, 16'sd32767);
        offer(-16'sd32768, 16'sd0);
        offer(16'sd32767, 16'sd0);
        offer(-16'sd32768, -16'sd32768);
        offer(16'sd32767, 16'sd32767);
        offer(-16'sd32768, 16'sd32767);
        offer(16'sd32767, 16'sd0);
        offer(-16'sd23170, -16'sd23170);
        offer(16'sd1, 16'sd0);
        offer(16'sd0, 16'sd1);
        offer(-16'sd1, 16'sd0);
        offer(16'sd0, -16'sd1);
        offer(-16'sd1, -16'sd1);
        offer(16'sd32767, -16'sd32768);
        random_burst(RANDOM_PER_PHASE);

        for (int p = 0; p < GAIN_PHASES; p++) begin
            g = (p < 6) ? GAIN_STEPS[p] : t_gain'($urandom);
            write_gain(g);
            if (p == 0) begin
                // full gain: near +pi and near -pi saturate both ways
                offer(16'sd32767, 16'sd0);
                offer(-16'sd32767, 16'sd100);
                offer(16'sd32767, 16'sd0);
                offer(-16'sd32767, -16'sd100);
                offer(-16'sd32768, 16'sd0);
            end
            random_burst(RANDOM_PER_PHASE);
        end

        drain();
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (fail_count == 0) begin
            $display("quadrature_fm_discriminator_core: match");
        end else begin
            $display("quadrature_fm_discriminator_core: mismatch");
        end
        $finish;
    end

endmodule
